// ===== design/ibm_ieee_float_converter_pkg.sv =====
package ibfc_pkg;

  typedef struct packed {
    logic        command;
    logic [31:0] operand_word;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic        overflowed;
    logic        precision_lost;
  } out_beat_t;

  localparam logic CmdIbmToIeee = 1'b0;
  localparam logic CmdIeeeToIbm = 1'b1;

  // position of the highest set bit of a 24-bit value, 0 when zero
  function automatic logic [4:0] top_bit24(input logic [23:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

// ===== design/ibm_ieee_float_converter.sv =====
// IBM hex float / IEEE single converter.
// Input channel: in_valid_i, in_stall_o, in_data_i (command, operand_word).
// Output channel: out_valid_o, out_stall_i, out_data_o (result_word,
// overflowed, precision_lost). command 0 turns an IBM word into IEEE single,
// command 1 turns an IEEE single into an IBM word.
// An accepted input beat is registered in stages 1, 2 and 3 before its result beat.
// Throughput is one beat per cycle while out_stall_i is low: the pipeline has
// three stages (leading bit search, shift, round and pack), one item each.
// When the receiver stalls, the full stages hold and empty stages still fill;
// in_stall_o is high only while all three stages are full and the output
// stage is stalled.
// Reset clears every valid bit; payload registers are not reset.
module ibm_ieee_float_converter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ibfc_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ibfc_pkg::out_beat_t out_data_o
);
  import ibfc_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3 = !v3_q || !out_stall_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // stage 1: unpack and find leading bit
  logic        s1_cmd_q, s1_sign_q;
  logic [23:0] s1_mag_q;
  logic [4:0]  s1_msb_q;
  logic [7:0]  s1_ex_q;
  logic        s1_zero_q, s1_nan_q, s1_inf_q;

  logic [23:0] mag_d;
  always_comb begin
    if (in_data_i.command == CmdIbmToIeee) begin
      mag_d = in_data_i.operand_word[23:0];
    end else if (in_data_i.operand_word[30:23] != 8'd0) begin
      mag_d = {1'b1, in_data_i.operand_word[22:0]};
    end else begin
      mag_d = {1'b0, in_data_i.operand_word[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_cmd_q  <= in_data_i.command;
      s1_sign_q <= in_data_i.operand_word[31];
      s1_mag_q  <= mag_d;
      s1_msb_q  <= top_bit24(mag_d);
      s1_ex_q   <= (in_data_i.command == CmdIbmToIeee) ?
                   {1'b0, in_data_i.operand_word[30:24]} : in_data_i.operand_word[30:23];
      s1_zero_q <= (mag_d == 24'd0);
      s1_nan_q  <= (in_data_i.command == CmdIeeeToIbm) &&
                   (in_data_i.operand_word[30:23] == 8'hFF) &&
                   (in_data_i.operand_word[22:0] != 23'd0);
      s1_inf_q  <= (in_data_i.command == CmdIeeeToIbm) &&
                   (in_data_i.operand_word[30:23] == 8'hFF) &&
                   (in_data_i.operand_word[22:0] == 23'd0);
    end
  end

  // stage 2: exponent and shift
  logic        s2_cmd_q, s2_sign_q, s2_zero_q, s2_nan_q, s2_inf_q;
  logic        s2_ovf_q, s2_norm_q;
  logic [7:0]  s2_exp_q;
  logic [23:0] s2_frac_q;
  logic [23:0] s2_rem_q;
  logic [23:0] s2_half_q;
  logic        s2_remhi_q;

  logic signed [11:0] ex_ibm, sh_ibm, q_ieee, s_ieee;
  logic [9:0]         qq;
  logic [23:0]        frac_d, rem_d, half_d;
  logic               remhi_d;
  logic [7:0]         exp_d;
  logic               ovf_d, norm_d;
  logic [5:0]         r;

  always_comb begin
    ex_ibm  = 12'(s1_msb_q) + 12'({s1_ex_q, 2'b00}) - 12'sd153;
    sh_ibm  = 12'({s1_ex_q, 2'b00}) - 12'sd131;
    q_ieee  = 12'(s1_msb_q) + ((s1_ex_q != 8'd0) ? 12'(s1_ex_q) - 12'sd150 : -12'sd149);
    qq      = 10'(q_ieee + 12'sd152);
    s_ieee  = 12'sd20 + 12'(qq[1:0]) - 12'(s1_msb_q);
    frac_d  = 24'd0;
    rem_d   = 24'd0;
    half_d  = 24'd0;
    remhi_d = 1'b0;
    exp_d   = 8'd0;
    ovf_d   = 1'b0;
    norm_d  = 1'b0;
    r       = 6'd0;
    if (s1_cmd_q == CmdIbmToIeee) begin
      if (ex_ibm >= 12'sd255) begin
        ovf_d = 1'b1;
      end else if (ex_ibm >= 12'sd1) begin
        norm_d = 1'b1;
        exp_d  = ex_ibm[7:0];
        frac_d = s1_mag_q << (5'd23 - s1_msb_q);
      end else if (sh_ibm >= 12'sd0) begin
        frac_d = s1_mag_q << sh_ibm[4:0];
      end else if (sh_ibm <= -12'sd32) begin
        remhi_d = 1'b1;
      end else begin
        r      = 6'(-sh_ibm);
        frac_d = 24'(s1_mag_q >> r);
        rem_d  = s1_mag_q & 24'((33'd1 << r) - 33'd1);
        half_d = 24'(33'd1 << (r - 6'd1));
      end
    end else begin
      exp_d = 8'(7'd27 + 7'(qq[9:2]));
      if (s_ieee >= 12'sd0) begin
        frac_d = s1_mag_q << s_ieee[4:0];
      end else begin
        r      = 6'(-s_ieee);
        frac_d = s1_mag_q >> r;
        rem_d  = s1_mag_q & 24'((25'd1 << r) - 25'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_sign_q  <= s1_sign_q;
      s2_zero_q  <= s1_zero_q;
      s2_nan_q   <= s1_nan_q;
      s2_inf_q   <= s1_inf_q;
      s2_ovf_q   <= ovf_d;
      s2_norm_q  <= norm_d;
      s2_exp_q   <= exp_d;
      s2_frac_q  <= frac_d;
      s2_rem_q   <= rem_d;
      s2_half_q  <= half_d;
      s2_remhi_q <= remhi_d;
    end
  end

  // stage 3: round and pack
  out_beat_t s3_q, s3_d;
  logic [23:0] qr;
  always_comb begin
    s3_d = '0;
    qr   = s2_frac_q;
    if (s2_cmd_q == CmdIbmToIeee) begin
      if (s2_zero_q) begin
        s3_d.result_word = {s2_sign_q, 31'd0};
      end else if (s2_ovf_q) begin
        s3_d.result_word = {s2_sign_q, 8'hFF, 23'd0};
        s3_d.overflowed  = 1'b1;
      end else if (s2_norm_q) begin
        s3_d.result_word = {s2_sign_q, s2_exp_q, s2_frac_q[22:0]};
      end else if (s2_remhi_q) begin
        s3_d.result_word    = {s2_sign_q, 31'd0};
        s3_d.precision_lost = 1'b1;
      end else begin
        // a half step past the fraction width is never reached: drop, no round
        if (s2_half_q != 24'd0 && (s2_rem_q > s2_half_q ||
            (s2_rem_q == s2_half_q && s2_frac_q[0]))) begin
          qr = s2_frac_q + 24'd1;
        end
        s3_d.result_word    = {s2_sign_q, 7'd0, qr};
        s3_d.precision_lost = (s2_rem_q != 24'd0);
      end
    end else begin
      if (s2_nan_q || s2_zero_q) begin
        s3_d.result_word = 32'd0;
      end else if (s2_inf_q) begin
        s3_d.result_word = {s2_sign_q, 31'h7FFFFFFF};
        s3_d.overflowed  = 1'b1;
      end else begin
        s3_d.result_word    = {s2_sign_q, s2_exp_q[6:0], s2_frac_q};
        s3_d.precision_lost = (s2_rem_q != 24'd0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

endmodule

// ===== verif/tb_ibm_ieee_float_converter.sv =====
module tb_ibm_ieee_float_converter;
  import ibfc_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_data_o;

  out_beat_t pending_results[$];
  int        error_count;
  int        beats_sent;
  int        beats_checked;
  int        idle_cycles;
  bit        rx_hold;
  bit        rx_random;

  ibm_ieee_float_converter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic int msb_pos(logic [31:0] v);
    int p;
    p = -1;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = i;
    end
    return p;
  endfunction

  function automatic out_beat_t ibm_to_ieee(logic [31:0] w);
    out_beat_t   r;
    logic [31:0] f;
    logic [31:0] rem;
    logic [31:0] half;
    logic [31:0] q;
    int          e;
    int          p;
    int          ex;
    int          sh;
    r = '0;
    f = {8'd0, w[23:0]};
    e = int'(w[30:24]);
    if (f == 0) begin
      r.result_word = {w[31], 31'd0};
      return r;
    end
    p  = msb_pos(f);
    ex = p + 4 * e - 153;
    if (ex >= 255) begin
      r.result_word = {w[31], 31'h7F80_0000};
      r.overflowed  = 1'b1;
    end else if (ex >= 1) begin
      r.result_word = {w[31], ex[7:0], 23'((f << (23 - p)))};
    end else begin
      sh = 4 * e - 131;
      if (sh >= 0) begin
        q = f << sh;
      end else if (-sh >= 32) begin
        q = 0;
        r.precision_lost = 1'b1;
      end else begin
        rem  = f & ((32'd1 << -sh) - 1);
        half = 32'd1 << (-sh - 1);
        q    = f >> -sh;
        if (rem > half || (rem == half && q[0])) q = q + 1;
        r.precision_lost = (rem != 0);
      end
      r.result_word = {w[31], 31'd0} | q;
    end
    return r;
  endfunction

  function automatic out_beat_t ieee_to_ibm(logic [31:0] w);
    out_beat_t   r;
    logic [31:0] big;
    logic [31:0] frac;
    int          k;
    int          msb;
    int          qq;
    int          x;
    int          s;
    r = '0;
    if (w[30:23] == 8'hFF) begin
      if (w[22:0] == 0) begin
        r.result_word = {w[31], 31'h7FFF_FFFF};
        r.overflowed  = 1'b1;
      end
      return r;
    end
    if (w[30:0] == 0) return r;
    if (w[30:23] != 0) begin
      big = {8'd0, 1'b1, w[22:0]};
      k   = int'(w[30:23]) - 150;
    end else begin
      big = {9'd0, w[22:0]};
      k   = -149;
    end
    msb = msb_pos(big);
    qq  = msb + k + 152;
    x   = 65 + (qq >> 2) - 38;
    s   = 20 + (qq & 3) - msb;
    if (s >= 0) begin
      frac = big << s;
    end else begin
      frac = big >> -s;
      r.precision_lost = ((big & ((32'd1 << -s) - 1)) != 0);
    end
    r.result_word = {w[31], x[6:0], frac[23:0]};
    return r;
  endfunction

  // valid stays high between back-to-back beats; drop it only before a gap
  task automatic send_word(logic cmd, logic [31:0] w);
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    in_data_i.command      <= cmd;
    in_data_i.operand_word <= w;
    pending_results.push_back(cmd == CmdIbmToIeee ? ibm_to_ieee(w) : ieee_to_ibm(w));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic test_ibm_directed();
    send_word(CmdIbmToIeee, 32'h0000_0000);
    send_word(CmdIbmToIeee, 32'hFF00_0000);
    send_word(CmdIbmToIeee, 32'h4110_0000);
    send_word(CmdIbmToIeee, 32'hC276_A000);
    send_word(CmdIbmToIeee, 32'h7FFF_FFFF);
    send_word(CmdIbmToIeee, 32'hFFFF_FFFF);
    send_word(CmdIbmToIeee, 32'h0000_0001);
    send_word(CmdIbmToIeee, 32'h80FF_FFFF);
    send_word(CmdIbmToIeee, 32'h2110_0000);
    send_word(CmdIbmToIeee, 32'h2118_0000);
    send_word(CmdIbmToIeee, 32'h1FFF_FFFF);
    send_word(CmdIbmToIeee, 32'h6100_0001);
  endtask

  task automatic test_ieee_directed();
    send_word(CmdIeeeToIbm, 32'h0000_0000);
    send_word(CmdIeeeToIbm, 32'h8000_0000);
    send_word(CmdIeeeToIbm, 32'h7FC0_0001);
    send_word(CmdIeeeToIbm, 32'hFF80_0001);
    send_word(CmdIeeeToIbm, 32'h7F80_0000);
    send_word(CmdIeeeToIbm, 32'hFF80_0000);
    send_word(CmdIeeeToIbm, 32'h0000_0001);
    send_word(CmdIeeeToIbm, 32'h807F_FFFF);
    send_word(CmdIeeeToIbm, 32'h3F80_0000);
    send_word(CmdIeeeToIbm, 32'h7F7F_FFFF);
    send_word(CmdIeeeToIbm, 32'hBF7F_FFFF);
    send_word(CmdIeeeToIbm, 32'h0080_0000);
  endtask

  task automatic test_random_words(int count);
    logic [31:0] w;
    for (int i = 0; i < count; i++) begin
      w = $urandom();
      case ($urandom_range(0, 5))
        0: w[23:0] = w[23:0] >> $urandom_range(0, 23);
        1: w[30:23] = $urandom_range(0, 2) == 0 ? 8'hFF : 8'h00;
        2: w[30:24] = $urandom_range(0, 40);
        default: ;
      endcase
      send_word(logic'($urandom_range(0, 1)), w);
    end
  endtask

  task automatic test_backpressure();
    rx_random = 1'b0;
    rx_hold   = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      test_random_words(20);
    join
    rx_random = 1'b1;
    drain_pipe();
  endtask

  // receiver stall, redrawn per beat
  initial begin
    int wait_left;
    out_stall_i = 1'b0;
    wait_left   = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        out_stall_i <= 1'b1;
      end else if (!rx_random) begin
        out_stall_i <= 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        wait_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        out_stall_i <= (wait_left != 0);
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall_i <= (wait_left != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    out_beat_t exp_beat;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, out_data_o);
        error_count++;
      end else begin
        exp_beat = pending_results.pop_front();
        if (exp_beat.result_word !== out_data_o.result_word) begin
          $display("%0t: result_word expected %h actual %h", $time,
                   exp_beat.result_word, out_data_o.result_word);
          error_count++;
        end
        if (exp_beat.overflowed !== out_data_o.overflowed) begin
          $display("%0t: overflowed expected %b actual %b", $time,
                   exp_beat.overflowed, out_data_o.overflowed);
          error_count++;
        end
        if (exp_beat.precision_lost !== out_data_o.precision_lost) begin
          $display("%0t: precision_lost expected %b actual %b", $time,
                   exp_beat.precision_lost, out_data_o.precision_lost);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 2000) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    error_count   = 0;
    beats_sent    = 0;
    beats_checked = 0;
    idle_cycles   = 0;
    rx_hold       = 1'b0;
    rx_random     = 1'b1;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ibm_directed();
    test_ieee_directed();
    drain_pipe();
    test_random_words(500);
    test_backpressure();
    test_random_words(500);
    drain_pipe();
    $display("Sent %0d words in both directions, checked %0d results", beats_sent,
             beats_checked);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ibm_ieee_float_converter_pkg.sv
design/ibm_ieee_float_converter.sv
verif/tb_ibm_ieee_float_converter.sv
